@@ rtl/core/handle_table_allocator_unit_macros.svh @@
// ----------------------------------------------------------------------------
// handle table allocator assertion macros
// concurrent checks on clk, held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef HANDLE_TABLE_ALLOCATOR_UNIT_MACROS_SVH
`define HANDLE_TABLE_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define HTA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HTA_ASSERT_NOW(lbl, ante, cons, msg)
`define HTA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/core/hta_pkg.sv @@
// ----------------------------------------------------------------------------
// hta_pkg
// shared widths, codes and reset values of the handle table allocator
// ----------------------------------------------------------------------------
package hta_pkg;

  // default table size
  localparam int NUM_HANDLES_DEF = 256;

  // field widths
  localparam int KIND_W     = 3;
  localparam int HANDLE_W   = 11;
  localparam int NUM_W      = 16;
  localparam int STATUS_W   = 2;
  localparam int LIMIT_W    = 9;
  localparam int FLOOR_W    = 8;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;

  // used bitmap word
  localparam int WORD_W      = 32;
  localparam int WORD_BITS_W = 5;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_ASSOC      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CHECK      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ALLOC_SPEC = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FREE       = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DISASSOC   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_ALLOC_LOW  = 3'd6;
  localparam logic [KIND_W-1:0] KIND_ALLOC_MAP  = 3'd7;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ERR  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BUSY = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HANDLE_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_FLOOR  = 1'b1;

  // reset values
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 9'd256;
  localparam logic [FLOOR_W-1:0] FLOOR_RST = 8'd3;
  localparam logic [NUM_W-1:0]   NO_NUMBER = 16'hFFFF;

endpackage

@@ rtl/core/hta_ram.sv @@
// ----------------------------------------------------------------------------
// hta_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module hta_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/handle_table_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// handle_table_allocator_unit
// table of local handles with used bits, mapped numbers and lowest-free alloc
// ----------------------------------------------------------------------------
// One operation at a time. After reset a clearing pass unmaps every handle and
// clears the used bitmap; no input is taken meanwhile, configuration writes
// are. Mapped numbers live in one ram with an entry per handle, the used bits
// in a second ram of 32-bit words. Every operation but allocation reads the
// rams when its input is taken, then loads the result register from ST_EXEC
// (one ram read, one read-modify-write). Allocation scans the bitmap word by
// word from the word holding max(min_handle, start_floor), reading each
// further word in ST_SRCH_RD and checking it in ST_SRCH_CHK, until a free
// handle is claimed or the handle limit is passed. The result register lets
// the result wait for out_ready without holding the next input, though a
// finished operation waits there while a previous result is still untaken.
// ----------------------------------------------------------------------------
`include "handle_table_allocator_unit_macros.svh"

module handle_table_allocator_unit #(
  parameter int NUM_HANDLES = hta_pkg::NUM_HANDLES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [hta_pkg::KIND_W-1:0]            in_kind,
  input  logic signed [hta_pkg::HANDLE_W-1:0]   in_handle,
  input  logic signed [hta_pkg::NUM_W-1:0]      in_system_number,
  input  logic signed [hta_pkg::HANDLE_W-1:0]   in_min_handle,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [hta_pkg::STATUS_W-1:0]          out_status,
  output logic signed [hta_pkg::NUM_W-1:0]      out_value,
  // configuration
  input  logic                                  cfg_we,
  input  logic [hta_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [hta_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int HIW   = $clog2(NUM_HANDLES);
  localparam int LIM_W = $clog2(NUM_HANDLES + 1);
  localparam int CW    = ((LIM_W > hta_pkg::HANDLE_W) ? LIM_W : hta_pkg::HANDLE_W) + 1;
  localparam int UD    = (NUM_HANDLES + hta_pkg::WORD_W - 1) / hta_pkg::WORD_W;
  localparam int UAW   = (UD > 1) ? $clog2(UD) : 1;
  localparam int WB    = hta_pkg::WORD_BITS_W;
  localparam int WW    = hta_pkg::WORD_W;
  localparam int MAGW  = hta_pkg::HANDLE_W - 1;

  typedef enum logic [4:0] {
    ST_CLEAR    = 5'b00001,
    ST_IDLE     = 5'b00010,
    ST_EXEC     = 5'b00100,
    ST_SRCH_RD  = 5'b01000,
    ST_SRCH_CHK = 5'b10000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [hta_pkg::KIND_W-1:0]      kind_r;
  logic [CW-1:0]                   h_r;
  logic                            ok_r;
  logic [hta_pkg::NUM_W-1:0]       num_r;
  logic [CW-1:0]                   lo_r;
  logic [UAW-1:0]                  w_r, w_nxt;
  logic [HIW-1:0]                  clr_r, clr_nxt;
  logic [hta_pkg::LIMIT_W-1:0]     limit_r;
  logic [hta_pkg::FLOOR_W-1:0]     floor_r;
  logic                            out_valid_r;
  logic [hta_pkg::STATUS_W-1:0]    out_status_r;
  logic [hta_pkg::NUM_W-1:0]       out_value_r;

  // ram ports
  logic                            map_we, map_re;
  logic [HIW-1:0]                  map_waddr, map_raddr;
  logic [hta_pkg::NUM_W-1:0]       map_wdata, map_rdata;
  logic                            used_we, used_re;
  logic [UAW-1:0]                  used_waddr, used_raddr;
  logic [WW-1:0]                   used_wdata, used_rdata;

  // derived values
  logic                            in_xfer;
  logic                            out_free;
  logic                            out_load;
  logic [hta_pkg::STATUS_W-1:0]    res_status;
  logic [hta_pkg::NUM_W-1:0]       res_value;
  logic [CW-1:0]                   eff_lim;
  logic [CW-1:0]                   floor_ext;
  logic [CW-1:0]                   in_h_ext, in_minh_ext, in_lo;
  logic                            in_ok;
  logic                            in_alloc;
  logic [UAW-1:0]                  h_word;
  logic [WB-1:0]                   h_bit;
  logic [WW-1:0]                   h_mask;
  logic [CW-1:0]                   base;
  logic [CW-1:0]                   next_base;
  logic [WW-1:0]                   free_vec;
  logic                            hit;
  logic [WB-1:0]                   hit_pos;
  logic [CW-1:0]                   found;

  // effective limit and floor
  assign eff_lim   = (CW'(limit_r) > CW'(NUM_HANDLES)) ? CW'(NUM_HANDLES) : CW'(limit_r);
  assign floor_ext = CW'(floor_r);

  // input decode
  assign in_h_ext    = {{(CW - MAGW){1'b0}}, in_handle[MAGW-1:0]};
  assign in_minh_ext = {{(CW - MAGW){1'b0}}, in_min_handle[MAGW-1:0]};
  assign in_ok       = !in_handle[hta_pkg::HANDLE_W-1] && (in_h_ext < eff_lim);
  assign in_lo       = (in_min_handle[hta_pkg::HANDLE_W-1] || (in_minh_ext < floor_ext))
                       ? floor_ext : in_minh_ext;
  assign in_alloc    = (in_kind == hta_pkg::KIND_ALLOC_LOW) ||
                       (in_kind == hta_pkg::KIND_ALLOC_MAP);

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // held handle split into bitmap word and bit
  assign h_word = UAW'(h_r >> WB);
  assign h_bit  = h_r[WB-1:0];
  assign h_mask = WW'(1) << h_bit;

  // bitmap word scan
  assign base      = CW'(w_r) << WB;
  assign next_base = base + CW'(WW);

  always_comb begin
    for (int j = 0; j < WW; j++) begin
      free_vec[j] = !used_rdata[j] && ((base | CW'(j)) >= lo_r) && ((base | CW'(j)) < eff_lim);
    end
  end

  // lowest free bit
  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int j = WW - 1; j >= 0; j--) begin
      if (free_vec[j]) begin
        hit     = 1'b1;
        hit_pos = WB'(j);
      end
    end
  end

  assign found = base | CW'(hit_pos);

  // sequencer and ram access
  always_comb begin
    state_nxt  = state_r;
    w_nxt      = w_r;
    clr_nxt    = clr_r;
    map_we     = 1'b0;
    map_waddr  = h_r[HIW-1:0];
    map_wdata  = hta_pkg::NO_NUMBER;
    map_re     = 1'b0;
    map_raddr  = in_h_ext[HIW-1:0];
    used_we    = 1'b0;
    used_waddr = h_word;
    used_wdata = used_rdata;
    used_re    = 1'b0;
    used_raddr = UAW'(in_h_ext >> WB);
    out_load   = 1'b0;
    res_status = hta_pkg::ST_ERR;
    res_value  = '0;

    case (state_r)
      // unmap every handle and clear the bitmap
      ST_CLEAR: begin
        map_we     = 1'b1;
        map_waddr  = clr_r;
        map_wdata  = hta_pkg::NO_NUMBER;
        used_we    = (CW'(clr_r) < CW'(UD));
        used_waddr = clr_r[UAW-1:0];
        used_wdata = '0;
        if (clr_r == HIW'(NUM_HANDLES - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + HIW'(1);
        end
      end

      // take an item and start its reads
      ST_IDLE: begin
        if (in_xfer) begin
          map_re  = 1'b1;
          used_re = 1'b1;
          if (in_alloc) begin
            used_raddr = UAW'(in_lo >> WB);
            w_nxt      = UAW'(in_lo >> WB);
            state_nxt  = (in_lo >= eff_lim) ? ST_EXEC : ST_SRCH_CHK;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end

      // single-entry read-modify-write
      ST_EXEC: begin
        case (kind_r)
          hta_pkg::KIND_ASSOC: begin
            if (!ok_r) begin
              res_status = hta_pkg::ST_BAD;
            end else if (!num_r[hta_pkg::NUM_W-1]) begin
              res_status = hta_pkg::ST_OK;
              map_we     = out_free;
              map_wdata  = num_r;
            end
          end
          hta_pkg::KIND_CHECK: begin
            if (ok_r) begin
              res_status = hta_pkg::ST_OK;
            end
          end
          hta_pkg::KIND_LOOKUP: begin
            if (ok_r && !map_rdata[hta_pkg::NUM_W-1]) begin
              res_status = hta_pkg::ST_OK;
              res_value  = map_rdata;
            end
          end
          hta_pkg::KIND_ALLOC_SPEC: begin
            if (!ok_r) begin
              res_status = hta_pkg::ST_BAD;
            end else if (!map_rdata[hta_pkg::NUM_W-1]) begin
              res_status = hta_pkg::ST_OK;
              res_value  = hta_pkg::NUM_W'(h_r);
              map_we     = out_free;
            end else if ((used_rdata & h_mask) != '0) begin
              res_status = hta_pkg::ST_BUSY;
            end else begin
              res_status = hta_pkg::ST_OK;
              res_value  = hta_pkg::NUM_W'(h_r);
              used_we    = out_free;
              used_wdata = used_rdata | h_mask;
            end
          end
          hta_pkg::KIND_FREE: begin
            if (!ok_r) begin
              res_status = hta_pkg::ST_BAD;
            end else begin
              res_status = hta_pkg::ST_OK;
              map_we     = out_free;
              used_we    = out_free;
              used_wdata = used_rdata & ~h_mask;
            end
          end
          hta_pkg::KIND_DISASSOC: begin
            if (ok_r && !map_rdata[hta_pkg::NUM_W-1]) begin
              res_status = hta_pkg::ST_OK;
              res_value  = map_rdata;
              map_we     = out_free && (h_r >= floor_ext);
            end
          end
          default: begin
            // allocation with an empty search range
            res_status = hta_pkg::ST_ERR;
          end
        endcase
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      // fetch the next bitmap word
      ST_SRCH_RD: begin
        used_re    = 1'b1;
        used_raddr = w_r;
        state_nxt  = ST_SRCH_CHK;
      end

      // claim the lowest free bit or move on
      ST_SRCH_CHK: begin
        if (hit) begin
          res_status = hta_pkg::ST_OK;
          res_value  = hta_pkg::NUM_W'(found);
          used_waddr = w_r;
          used_wdata = used_rdata | (WW'(1) << hit_pos);
          map_waddr  = found[HIW-1:0];
          map_wdata  = num_r;
          if (out_free) begin
            used_we   = 1'b1;
            map_we    = (kind_r == hta_pkg::KIND_ALLOC_MAP);
            out_load  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (next_base < eff_lim) begin
          w_nxt     = w_r + UAW'(1);
          state_nxt = ST_SRCH_RD;
        end else if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= hta_pkg::LIMIT_RST;
      floor_r <= hta_pkg::FLOOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hta_pkg::REG_HANDLE_LIMIT: limit_r <= cfg_wdata[hta_pkg::LIMIT_W-1:0];
        hta_pkg::REG_START_FLOOR:  floor_r <= cfg_wdata[hta_pkg::FLOOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    if (in_xfer) begin
      kind_r <= in_kind;
      h_r    <= in_h_ext;
      ok_r   <= in_ok;
      num_r  <= in_system_number;
      lo_r   <= in_lo;
    end
    if (out_load) begin
      out_status_r <= res_status;
      out_value_r  <= res_value;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;

  // mapped numbers, one entry per handle
  hta_ram #(
    .WIDTH (hta_pkg::NUM_W),
    .DEPTH (NUM_HANDLES)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // used bitmap, one word per 32 handles
  hta_ram #(
    .WIDTH (WW),
    .DEPTH (UD)
  ) u_used_ram (
    .clk   (clk),
    .we    (used_we),
    .waddr (used_waddr),
    .wdata (used_wdata),
    .re    (used_re),
    .raddr (used_raddr),
    .rdata (used_rdata)
  );

  // checks
  `HTA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while an item is at work")
  `HTA_ASSERT_NOW(a_clear_quiet, state_r == ST_CLEAR, !in_ready && !out_valid_r, "transfer during clearing pass")
  `HTA_ASSERT_NOW(a_scan_in_range, state_r == ST_SRCH_CHK, base < eff_lim, "bitmap scan beyond limit")
  `HTA_ASSERT_NOW(a_used_write_owner, used_we, state_r == ST_CLEAR || out_load, "bitmap written without a result")
  `HTA_ASSERT_NEXT(a_load_goes_idle, out_load, state_r == ST_IDLE && out_valid_r, "result load did not finish the item")

endmodule
